// File: rtl/ppd_pkg.sv
`default_nettype none

package ppd_pkg;

    localparam int IN_W   = 288;
    localparam int DIST_W = 32;
    localparam int REM_W  = 128;
    localparam int QS_W   = 96;
    localparam int S_W    = 64;

    // state carried through the square-root/divide chain
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QS_W-1:0]   qs;
        logic [DIST_W-1:0] q;
        logic [S_W-1:0]    s;
        logic              sat;
        logic              deg;
    } iter_t;

endpackage

`default_nettype wire

// File: rtl/ppd_front.sv
`default_nettype none

module ppd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [ppd_pkg::IN_W-1:0] in_data,
    output logic                       out_valid,
    output ppd_pkg::iter_t             out_item
);
    import ppd_pkg::*;

    logic signed [31:0] px, py, pz, cx, cy, cz;
    logic signed [15:0] a0, a1, a2, b0, b1, b2;

    assign px = in_data[31:0];
    assign py = in_data[63:32];
    assign pz = in_data[95:64];
    assign cx = in_data[127:96];
    assign cy = in_data[159:128];
    assign cz = in_data[191:160];
    assign a0 = in_data[207:192];
    assign a1 = in_data[223:208];
    assign a2 = in_data[239:224];
    assign b0 = in_data[255:240];
    assign b1 = in_data[271:256];
    assign b2 = in_data[287:272];

    logic [6:0] v_reg;

    logic signed [32:0] d1_reg [3];
    logic signed [31:0] ab_reg [6];
    logic signed [32:0] d2_reg [3];
    logic signed [32:0] n_reg  [3];
    logic signed [65:0] dn_reg [3];
    logic        [63:0] nn_reg [3];
    logic signed [67:0] dot_reg;
    logic        [63:0] s4_reg;
    logic        [63:0] dl_reg;
    logic        [63:0] s5_reg;
    logic               sat5_reg;
    logic               deg5_reg;
    logic        [63:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic        [63:0] s6_reg;
    logic               sat6_reg;
    logic               deg6_reg;
    iter_t              item_reg;

    logic [67:0] mag;
    assign mag = dot_reg[67] ? 68'(-dot_reg) : 68'(dot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: offset from centre, axis cross terms
            d1_reg[0] <= 33'(px) - 33'(cx);
            d1_reg[1] <= 33'(py) - 33'(cy);
            d1_reg[2] <= 33'(pz) - 33'(cz);
            ab_reg[0] <= 32'(a1) * 32'(b2);
            ab_reg[1] <= 32'(a2) * 32'(b1);
            ab_reg[2] <= 32'(a2) * 32'(b0);
            ab_reg[3] <= 32'(a0) * 32'(b2);
            ab_reg[4] <= 32'(a0) * 32'(b1);
            ab_reg[5] <= 32'(a1) * 32'(b0);
            // stage 2: normal
            d2_reg   <= d1_reg;
            n_reg[0] <= 33'(ab_reg[0]) - 33'(ab_reg[1]);
            n_reg[1] <= 33'(ab_reg[2]) - 33'(ab_reg[3]);
            n_reg[2] <= 33'(ab_reg[4]) - 33'(ab_reg[5]);
            // stage 3: products
            for (int i = 0; i < 3; i++)
            begin
                dn_reg[i] <= 66'(d2_reg[i]) * 66'(n_reg[i]);
                nn_reg[i] <= 64'(66'(n_reg[i]) * 66'(n_reg[i]));
            end
            // stage 4: sums
            dot_reg <= 68'(dn_reg[0]) + 68'(dn_reg[1]) + 68'(dn_reg[2]);
            s4_reg  <= nn_reg[0] + nn_reg[1] + nn_reg[2];
            // stage 5: magnitude and special cases
            dl_reg   <= mag[63:0];
            sat5_reg <= |mag[67:64];
            s5_reg   <= s4_reg;
            deg5_reg <= (s4_reg == '0);
            // stage 6: partial products of the square
            hh_reg   <= 64'(dl_reg[63:32]) * 64'(dl_reg[63:32]);
            hl_reg   <= 64'(dl_reg[63:32]) * 64'(dl_reg[31:0]);
            lh_reg   <= 64'(dl_reg[31:0]) * 64'(dl_reg[63:32]);
            ll_reg   <= 64'(dl_reg[31:0]) * 64'(dl_reg[31:0]);
            s6_reg   <= s5_reg;
            sat6_reg <= sat5_reg;
            deg6_reg <= deg5_reg;
            // stage 7: dot squared
            item_reg.rem <= {hh_reg, 64'd0} + (REM_W'(hl_reg) << 32)
                          + (REM_W'(lh_reg) << 32) + REM_W'(ll_reg);
            item_reg.qs  <= '0;
            item_reg.q   <= '0;
            item_reg.s   <= s6_reg;
            item_reg.sat <= sat6_reg;
            item_reg.deg <= deg6_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/ppd_root_step.sv
`default_nettype none

module ppd_root_step #(
    parameter int BIT = 31
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  ppd_pkg::iter_t  in_item,
    output logic            out_valid,
    output ppd_pkg::iter_t  out_item
);
    import ppd_pkg::*;

    // (q + 2^k)^2 s - q^2 s = q s 2^(k+1) + s 2^(2k)
    logic [REM_W:0] trial;
    logic           fit;

    assign trial = ((REM_W + 1)'(in_item.qs) << (BIT + 1))
                 + ((REM_W + 1)'(in_item.s) << (2 * BIT));
    assign fit   = trial <= {1'b0, in_item.rem};

    logic  valid_reg;
    iter_t item_reg;
    iter_t item_next;

    always_comb
    begin
        item_next = in_item;
        if (fit)
        begin
            item_next.rem    = in_item.rem - trial[REM_W-1:0];
            item_next.qs     = in_item.qs + (QS_W'(in_item.s) << BIT);
            item_next.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/point_to_plane_distance.sv
`default_nettype none

// Point-to-plane distance: floor(|(p - c) . (a x b)| / |a x b|) in unsigned Q16.16,
// saturated at all ones; parallel or zero axes give 0 with tuser set. One request
// is taken per clock while the output is not held back. Seven stages form the
// offset, normal, dot product and its exact square, 32 stages each resolve one
// quotient bit by a compare and subtract, one stage holds the output. The whole
// pipeline advances together and freezes while the output is held back.
module point_to_plane_distance (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z, centre_x, centre_y, centre_z, first_axis_x,
    // first_axis_y, first_axis_z, second_axis_x, second_axis_y, second_axis_z
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // distance
    output logic [31:0]       m_tdata,
    // degenerate
    output logic [0:0]        m_tuser
);
    import ppd_pkg::*;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic  chain_valid [33];
    iter_t chain_item  [33];

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    for (genvar g = 0; g < DIST_W; g++)
    begin : g_step
        ppd_root_step #(.BIT(DIST_W - 1 - g)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g + 1]),
            .out_item  (chain_item[g + 1])
        );
    end

    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[DIST_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= chain_item[DIST_W].deg;
            if (chain_item[DIST_W].deg)
                dist_reg <= '0;
            else if (chain_item[DIST_W].sat)
                dist_reg <= '1;
            else
                dist_reg <= chain_item[DIST_W].q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dist_reg;
    assign m_tuser  = deg_reg;

endmodule

`default_nettype wire

// File: rtl/ppd_checker.sv
`default_nettype none

module ppd_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [287:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // a waiting request keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("request changed while stalled");

    // degenerate planes report zero distance
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result with nonzero distance");

    // input is only held off by a stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // no request accepted right after reset shows up at once
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind point_to_plane_distance ppd_checker u_ppd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
